// File: src/fbsf_pkg.sv
// Shared types, constants and helper functions for the framebuffer shape fill block.
`default_nettype none

package fbsf_pkg;

  // Width of a signed scan coordinate; covers every corner a command can reach.
  localparam int CW    = 13;
  localparam int OFF_W = 11;
  localparam int MAG_W = 9;
  localparam int SQ_W  = 18;
  localparam int LIM_W = 19;

  typedef logic signed [CW-1:0]    coord_t;
  typedef logic signed [OFF_W-1:0] offset_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_RECT  = 2'd1,
    OP_CIRC  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [10:0] x_pos;
    logic [10:0] y_pos;
    logic [9:0]  rect_width;
    logic [9:0]  rect_height;
    logic [8:0]  radius;
    logic [31:0] colour;
  } cmd_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic clipped;
    logic is_read;
  } stat_t;

  function automatic coord_t ext11(input logic [10:0] v);
    return coord_t'({{(CW-11){v[10]}}, v});
  endfunction

  // Distance term of the circle test: offsets past the center count one extra.
  function automatic logic [MAG_W-1:0] mag(input offset_t off);
    offset_t t;
    t = (off > offset_t'(0)) ? off + offset_t'(1) : -off;
    return t[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/fbsf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module fbsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: src/fbsf_seq.sv
// Command sequencer: walks the pixels of each command and drives the frame memory.
`default_nettype none

module fbsf_seq import fbsf_pkg::*; #(
  parameter int FB_WIDTH  = 128,
  parameter int FB_HEIGHT = 128
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  input  wire cmd_t                                   cmd,
  input  wire logic                                   res_ready,
  output stat_t                                       stat,
  output logic                                        ram_we,
  output logic [$clog2(FB_WIDTH*FB_HEIGHT)-1:0]       ram_waddr,
  output logic [31:0]                                 ram_wdata,
  output logic                                        ram_re,
  output logic [$clog2(FB_WIDTH*FB_HEIGHT)-1:0]       ram_raddr
);

  localparam int DEPTH  = FB_WIDTH * FB_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(FB_WIDTH);
  localparam int ROW_W  = $clog2(FB_HEIGHT);
  localparam coord_t FBW_S = CW'(FB_WIDTH);
  localparam coord_t FBH_S = CW'(FB_HEIGHT);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_RECT  = 6'b000100,
    S_CIRC  = 6'b001000,
    S_READ  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic                clip_r, clip_nxt;
  logic                read_r, read_nxt;
  logic [31:0]         colour_r, colour_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  coord_t              col_r, col_nxt;
  coord_t              row_r, row_nxt;
  coord_t              col_start_r, col_start_nxt;
  coord_t              col_end_r, col_end_nxt;
  coord_t              row_end_r, row_end_nxt;
  offset_t             off_c_r, off_c_nxt;
  offset_t             off_r_r, off_r_nxt;
  offset_t             off_start_r, off_start_nxt;
  logic [SQ_W-1:0]     dy2_r, dy2_nxt;
  logic [LIM_W-1:0]    lim_r, lim_nxt;

  coord_t              x_e, y_e, r_e;
  offset_t             off_init, off_r_inc;
  logic [MAG_W-1:0]    mx, my_next;
  logic [SQ_W-1:0]     dx2;
  logic [9:0]          r1;
  logic                in_range, hit, col_last, row_last;
  logic [ADDR_W-1:0]   pix_addr;

  assign x_e      = ext11(cmd.x_pos);
  assign y_e      = ext11(cmd.y_pos);
  assign r_e      = coord_t'({4'b0, cmd.radius});
  assign off_init = offset_t'(0) - offset_t'({2'b0, cmd.radius});
  assign r1       = {1'b0, cmd.radius} + 10'd1;

  assign in_range = (col_r >= coord_t'(0)) && (col_r < FBW_S) &&
                    (row_r >= coord_t'(0)) && (row_r < FBH_S);
  assign pix_addr = ADDR_W'({{(ADDR_W-ROW_W){1'b0}}, row_r[ROW_W-1:0]} * ADDR_W'(FB_WIDTH)) +
                    {{(ADDR_W-COL_W){1'b0}}, col_r[COL_W-1:0]};

  assign col_last  = (col_r == col_end_r);
  assign row_last  = (row_r == row_end_r);
  assign off_r_inc = off_r_r + offset_t'(1);
  assign mx        = mag(off_c_r);
  assign my_next   = mag(off_r_inc);
  assign dx2       = {{(SQ_W-MAG_W){1'b0}}, mx} * {{(SQ_W-MAG_W){1'b0}}, mx};
  assign hit       = ({1'b0, dx2} + {1'b0, dy2_r}) < lim_r;

  always_comb begin
    state_nxt     = state_r;
    clip_nxt      = clip_r;
    read_nxt      = read_r;
    colour_nxt    = colour_r;
    clr_nxt       = clr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    col_start_nxt = col_start_r;
    col_end_nxt   = col_end_r;
    row_end_nxt   = row_end_r;
    off_c_nxt     = off_c_r;
    off_r_nxt     = off_r_r;
    off_start_nxt = off_start_r;
    dy2_nxt       = dy2_r;
    lim_nxt       = lim_r;
    ram_we        = 1'b0;
    ram_waddr     = pix_addr;
    ram_wdata     = colour_r;
    ram_re        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          clip_nxt   = 1'b0;
          read_nxt   = (cmd.op == OP_READ);
          colour_nxt = cmd.colour;
          clr_nxt    = '0;
          case (cmd.op)
            OP_CLEAR: begin
              state_nxt = S_CLEAR;
            end
            OP_RECT: begin
              col_nxt       = x_e;
              row_nxt       = y_e;
              col_start_nxt = x_e;
              col_end_nxt   = x_e + coord_t'({3'b0, cmd.rect_width}) - coord_t'(1);
              row_end_nxt   = y_e + coord_t'({3'b0, cmd.rect_height}) - coord_t'(1);
              state_nxt     = (cmd.rect_width == '0 || cmd.rect_height == '0) ? S_DONE : S_RECT;
            end
            OP_CIRC: begin
              col_nxt       = x_e - r_e;
              row_nxt       = y_e - r_e;
              col_start_nxt = x_e - r_e;
              col_end_nxt   = x_e + r_e - coord_t'(1);
              row_end_nxt   = y_e + r_e - coord_t'(1);
              off_c_nxt     = off_init;
              off_r_nxt     = off_init;
              off_start_nxt = off_init;
              dy2_nxt       = {{(SQ_W-MAG_W){1'b0}}, cmd.radius} *
                              {{(SQ_W-MAG_W){1'b0}}, cmd.radius};
              lim_nxt       = {{(LIM_W-10){1'b0}}, r1} * {{(LIM_W-10){1'b0}}, r1};
              state_nxt     = (cmd.radius == '0) ? S_DONE : S_CIRC;
            end
            OP_READ: begin
              col_nxt   = x_e;
              row_nxt   = y_e;
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_DONE;
        end else begin
          clr_nxt = clr_r + ADDR_W'(1);
        end
      end
      S_RECT: begin
        ram_we = in_range;
        if (!in_range) begin
          clip_nxt = 1'b1;
        end
        if (col_last) begin
          col_nxt = col_start_r;
          if (row_last) begin
            state_nxt = S_DONE;
          end else begin
            row_nxt = row_r + coord_t'(1);
          end
        end else begin
          col_nxt = col_r + coord_t'(1);
        end
      end
      S_CIRC: begin
        ram_we = hit && in_range;
        if (hit && !in_range) begin
          clip_nxt = 1'b1;
        end
        if (col_last) begin
          col_nxt   = col_start_r;
          off_c_nxt = off_start_r;
          if (row_last) begin
            state_nxt = S_DONE;
          end else begin
            row_nxt   = row_r + coord_t'(1);
            off_r_nxt = off_r_inc;
            dy2_nxt   = {{(SQ_W-MAG_W){1'b0}}, my_next} * {{(SQ_W-MAG_W){1'b0}}, my_next};
          end
        end else begin
          col_nxt   = col_r + coord_t'(1);
          off_c_nxt = off_c_r + offset_t'(1);
        end
      end
      S_READ: begin
        ram_re    = in_range;
        clip_nxt  = !in_range;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ram_raddr = pix_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      clip_r  <= 1'b0;
      read_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clip_r  <= clip_nxt;
      read_r  <= read_nxt;
    end
  end

  always_ff @(posedge clk) begin
    colour_r    <= colour_nxt;
    clr_r       <= clr_nxt;
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    col_start_r <= col_start_nxt;
    col_end_r   <= col_end_nxt;
    row_end_r   <= row_end_nxt;
    off_c_r     <= off_c_nxt;
    off_r_r     <= off_r_nxt;
    off_start_r <= off_start_nxt;
    dy2_r       <= dy2_nxt;
    lim_r       <= lim_nxt;
  end

  assign stat.idle    = (state_r == S_IDLE);
  assign stat.done    = (state_r == S_DONE);
  assign stat.clipped = clip_r;
  assign stat.is_read = read_r;

endmodule

`default_nettype wire

// File: src/framebuffer_shape_fill.sv
// Framebuffer shape fill: clear, rectangle fill, circle fill and pixel read on a pixel store.
//
// Usage: one command item enters on the in_ channel (valid/stall) and gives exactly one
// result item on the out_ channel: pixel_data (the read pixel, zero otherwise) and clipped.
// Commands run one at a time; in_stall is high from acceptance until the result has been
// moved into the output register, so the next command can enter while a result still waits.
// Work per command: a clear walks all FB_WIDTH*FB_HEIGHT pixels, a rectangle
// rect_width*rect_height pixels, a circle its 2*radius by 2*radius box, a read one pixel,
// and an empty shape none. The sequencer visits one pixel per cycle, including pixels that
// fall outside the buffer, which the single write port of the frame memory does not write.
// Reset clears the control state only; the frame memory holds garbage until a clear.
// No clearing pass runs after reset, so software issues a clear before any read.
// When out_stall is high the result holds in the output register; a finished command
// then waits in its done state until the register frees, with in_stall kept high.
`default_nettype none

module framebuffer_shape_fill import fbsf_pkg::*; #(
  parameter int FB_WIDTH  = 128,
  parameter int FB_HEIGHT = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [10:0] in_x_pos,
  input  wire logic [10:0] in_y_pos,
  input  wire logic [9:0]  in_rect_width,
  input  wire logic [9:0]  in_rect_height,
  input  wire logic [8:0]  in_radius,
  input  wire logic [31:0] in_colour,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_pixel_data,
  output logic             out_clipped
);

  localparam int DEPTH  = FB_WIDTH * FB_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  cmd_t              cmd;
  stat_t             stat;
  logic              start, res_ready, load;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;

  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_pixel_r;
  logic              out_clip_r;

  assign cmd.op          = op_t'(in_op);
  assign cmd.x_pos       = in_x_pos;
  assign cmd.y_pos       = in_y_pos;
  assign cmd.rect_width  = in_rect_width;
  assign cmd.rect_height = in_rect_height;
  assign cmd.radius      = in_radius;
  assign cmd.colour      = in_colour;

  assign in_stall  = !stat.idle;
  assign start     = in_valid && stat.idle;
  assign res_ready = !out_valid_r || !out_stall;
  assign load      = stat.done && res_ready;

  fbsf_seq #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (cmd),
    .res_ready (res_ready),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  fbsf_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Read data from the memory is valid during the done state of a read.
  always_ff @(posedge clk) begin
    if (load) begin
      out_pixel_r <= (stat.is_read && !stat.clipped) ? ram_rdata : '0;
      out_clip_r  <= stat.clipped;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_data = out_pixel_r;
  assign out_clipped    = out_clip_r;

endmodule

`default_nettype wire
